// File: rtl/ptt_pkg.sv
// ============================================================================
// ptt_pkg: shared types and codes of the periodic timer table
// Operation, result and status codes, the entry record held by each cell,
// and the control bundle that the table controller sends to every cell.
// ============================================================================
package ptt_pkg;

  localparam int MAX_TIMERS_DEF = 16;

  localparam logic [1:0] FUNC_SET   = 2'd0;
  localparam logic [1:0] FUNC_CLOSE = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  localparam logic [1:0] KIND_SET   = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_FIRED = 2'd2;
  localparam logic [1:0] KIND_DONE  = 2'd3;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_DUPLICATE = 2'd2;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] reload;
    logic [31:0] count;
  } entry_t;

  typedef struct packed {
    logic wr;
    logic shift;
    logic tick;
    logic active;
    logic scan;
  } cell_ctrl_t;

endpackage

// File: rtl/ptt_cell.sv
// ============================================================================
// ptt_cell: one slot of the timer table
// Holds one timer entry and one report stage. Entries move down from the
// upper neighbor on a close, and report stages move down during a scan.
// ============================================================================
module ptt_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  ptt_pkg::cell_ctrl_t ctrl,
  input  logic [31:0]        wr_id,
  input  logic [31:0]        wr_reload,
  input  logic [31:0]        cmp_id,
  input  ptt_pkg::entry_t    nb_entry,
  input  logic               nb_rpt_flag,
  input  logic [31:0]        nb_rpt_id,
  output ptt_pkg::entry_t    entry,
  output logic               match,
  output logic               rpt_flag,
  output logic [31:0]        rpt_id
);

  ptt_pkg::entry_t entry_r;
  logic            rpt_flag_r;
  logic [31:0]     rpt_id_r;
  logic            zero;

  assign zero     = (entry_r.count == 32'd0);
  assign entry    = entry_r;
  assign match    = (entry_r.id == cmp_id);
  assign rpt_flag = rpt_flag_r;
  assign rpt_id   = rpt_id_r;

  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      entry_r.id     <= wr_id;
      entry_r.reload <= wr_reload;
      entry_r.count  <= wr_reload;
    end else if (ctrl.shift) begin
      entry_r <= nb_entry;
    end else if (ctrl.tick && ctrl.active) begin
      entry_r.count <= zero ? entry_r.reload : (entry_r.count - 32'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rpt_flag_r <= 1'b0;
    end else if (ctrl.tick) begin
      rpt_flag_r <= ctrl.active && zero;
    end else if (ctrl.scan) begin
      rpt_flag_r <= nb_rpt_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.tick) begin
      rpt_id_r <= entry_r.id;
    end else if (ctrl.scan) begin
      rpt_id_r <= nb_rpt_id;
    end
  end

endmodule

// File: rtl/periodic_timer_table.sv
// ============================================================================
// periodic_timer_table: ordered table of periodic timers
// A row of cells holds the timers oldest first; a controller answers set and
// close requests and walks the fired timers out of the row on every tick.
// ============================================================================
// Set and close requests are answered in the cycle after they are accepted.
// A tick request keeps the input closed while the report chain shifts toward
// cell 0 until no fired timer is left, then done follows. The scan also waits
// whenever a held result is not taken, and goes on once it is taken.
// A new request enters while a result is held only if it is taken that cycle.
// Reset clears the timer count, the system time and the output valid.
module periodic_timer_table #(
  parameter int MAX_TIMERS = ptt_pkg::MAX_TIMERS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_timer_id,
  input  logic [31:0] in_reload_ticks,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [1:0]  out_status,
  output logic [31:0] out_fired_id,
  output logic [31:0] out_system_time,
  output logic        out_last
);

  localparam int CNTW = $clog2(MAX_TIMERS + 1);

  typedef enum logic {ST_IDLE, ST_SCAN} state_t;

  state_t            st_r, st_nxt;
  logic [CNTW-1:0]   active_count_r, active_count_nxt;
  logic [31:0]       tick_total_r, tick_total_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_kind_r, out_kind_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [31:0]       out_id_r, out_id_nxt;
  logic [31:0]       out_time_r, out_time_nxt;
  logic              out_last_r, out_last_nxt;

  ptt_pkg::entry_t     ent [MAX_TIMERS+1];
  logic                rflag [MAX_TIMERS+1];
  logic [31:0]         rid [MAX_TIMERS+1];
  ptt_pkg::cell_ctrl_t ctrl [MAX_TIMERS];
  logic [MAX_TIMERS-1:0] match_raw;
  logic [MAX_TIMERS-1:0] match_act;
  logic [MAX_TIMERS-1:0] match_pre;
  logic [MAX_TIMERS-1:0] flags;

  logic out_free, accept, any_match, full, set_ok, close_ok, tick_go, scan_go;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (st_r == ST_IDLE) && out_free;
  assign accept    = in_valid && in_ready;
  assign any_match = |match_act;
  assign full      = (active_count_r >= CNTW'(MAX_TIMERS));
  assign set_ok    = accept && (in_func == ptt_pkg::FUNC_SET) && !full && !any_match;
  assign close_ok  = accept && (in_func == ptt_pkg::FUNC_CLOSE) && any_match;
  assign tick_go   = accept && (in_func == ptt_pkg::FUNC_TICK);
  assign scan_go   = (st_r == ST_SCAN) && out_free && (|flags);

  assign ent[MAX_TIMERS]   = '0;
  assign rflag[MAX_TIMERS] = 1'b0;
  assign rid[MAX_TIMERS]   = '0;

  always_comb begin
    for (int i = 0; i < MAX_TIMERS; i++) begin
      match_act[i] = match_raw[i] && (CNTW'(i) < active_count_r);
      flags[i]     = rflag[i];
    end
    match_pre[0] = match_act[0];
    for (int i = 1; i < MAX_TIMERS; i++) begin
      match_pre[i] = match_pre[i-1] || match_act[i];
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_TIMERS; i++) begin
      ctrl[i].wr     = set_ok && (CNTW'(i) == active_count_r);
      ctrl[i].shift  = close_ok && match_pre[i] &&
                       ((CNTW + 1)'(i + 1) < {1'b0, active_count_r});
      ctrl[i].tick   = tick_go;
      ctrl[i].active = (CNTW'(i) < active_count_r);
      ctrl[i].scan   = scan_go;
    end
  end

  for (genvar g = 0; g < MAX_TIMERS; g++) begin : g_cell
    ptt_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl[g]),
      .wr_id       (in_timer_id),
      .wr_reload   (in_reload_ticks),
      .cmp_id      (in_timer_id),
      .nb_entry    (ent[g+1]),
      .nb_rpt_flag (rflag[g+1]),
      .nb_rpt_id   (rid[g+1]),
      .entry       (ent[g]),
      .match       (match_raw[g]),
      .rpt_flag    (rflag[g]),
      .rpt_id      (rid[g])
    );
  end

  always_comb begin
    st_nxt           = st_r;
    active_count_nxt = active_count_r;
    tick_total_nxt   = tick_total_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_kind_nxt     = out_kind_r;
    out_status_nxt   = out_status_r;
    out_id_nxt       = out_id_r;
    out_time_nxt     = out_time_r;
    out_last_nxt     = out_last_r;
    if (accept) begin
      case (in_func)
        ptt_pkg::FUNC_SET: begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = ptt_pkg::KIND_SET;
          out_id_nxt     = in_timer_id;
          out_time_nxt   = '0;
          out_last_nxt   = 1'b1;
          if (full) begin
            out_status_nxt = ptt_pkg::STAT_FULL;
          end else if (any_match) begin
            out_status_nxt = ptt_pkg::STAT_DUPLICATE;
          end else begin
            out_status_nxt   = ptt_pkg::STAT_OK;
            active_count_nxt = active_count_r + CNTW'(1);
          end
        end
        ptt_pkg::FUNC_CLOSE: begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = ptt_pkg::KIND_CLOSE;
          out_id_nxt     = in_timer_id;
          out_time_nxt   = '0;
          out_last_nxt   = 1'b1;
          if (any_match) begin
            out_status_nxt   = ptt_pkg::STAT_OK;
            active_count_nxt = active_count_r - CNTW'(1);
          end else begin
            out_status_nxt = ptt_pkg::STAT_NOT_FOUND;
          end
        end
        ptt_pkg::FUNC_TICK: begin
          tick_total_nxt = tick_total_r + 32'd1;
          st_nxt         = ST_SCAN;
        end
        default: begin
        end
      endcase
    end else if ((st_r == ST_SCAN) && out_free) begin
      if (|flags) begin
        if (flags[0]) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = ptt_pkg::KIND_FIRED;
          out_status_nxt = ptt_pkg::STAT_OK;
          out_id_nxt     = rid[0];
          out_time_nxt   = '0;
          out_last_nxt   = 1'b0;
        end
      end else begin
        out_valid_nxt  = 1'b1;
        out_kind_nxt   = ptt_pkg::KIND_DONE;
        out_status_nxt = ptt_pkg::STAT_OK;
        out_id_nxt     = '0;
        out_time_nxt   = tick_total_r;
        out_last_nxt   = 1'b1;
        st_nxt         = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r           <= ST_IDLE;
      active_count_r <= '0;
      tick_total_r   <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      st_r           <= st_nxt;
      active_count_r <= active_count_nxt;
      tick_total_r   <= tick_total_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    out_kind_r   <= out_kind_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_time_r   <= out_time_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_status      = out_status_r;
  assign out_fired_id    = out_id_r;
  assign out_system_time = out_time_r;
  assign out_last        = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    active_count_r <= CNTW'(MAX_TIMERS))
    else $error("timer count above table size");

  a_set_grows: assert property (@(posedge clk) disable iff (!rst_n)
    set_ok |=> active_count_r == $past(active_count_r) + CNTW'(1))
    else $error("accepted set did not add an entry");

  a_scan_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SCAN) |=> active_count_r == $past(active_count_r))
    else $error("table size changed during a tick scan");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == ptt_pkg::KIND_DONE)) |-> out_last_r)
    else $error("tick done without last");

endmodule
